// ----- hw/rtl/wbps_pkg.sv -----
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int SIG_BYTES       = 16;
    localparam int SIG_IDX_W       = 4;
    localparam int APB_DATA_W      = 64;
    localparam int APB_ADDR_W      = 5;
    localparam int REG_IDX_W       = 2;
    localparam int CARE_W          = 16;
    localparam int PLEN_W          = 5;
    localparam int RESULT_OFF_W    = 32;

    localparam logic [REG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CARE     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_PLEN     = 2'd3;

    typedef logic [SIG_BYTES-1:0][7:0] t_sig;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/wbps_cell.sv -----
// ----------------------------------------------------------------------------
// wbps_cell
// One window cell: holds one history byte, compares the byte arriving from
// its neighbor against the signature byte aligned to this cell.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cell #(
    parameter int IDX   = 0,
    parameter int LEN_W = 6
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wbps_pkg::t_cell_ctl          i_ctl,
    input  wire  [7:0]                   i_byte,
    input  wire  [LEN_W-1:0]             i_len,
    input  wbps_pkg::t_sig               i_sig,
    input  wire  [wbps_pkg::CARE_W-1:0]  i_care,
    output logic [7:0]                   o_byte,
    output logic                         o_match
);
    import wbps_pkg::*;

    localparam logic [LEN_W-1:0] CELL_K = LEN_W'(IDX);
    localparam logic [LEN_W-1:0] SIG_N  = LEN_W'(SIG_BYTES);

    logic [7:0]       r_byte;
    logic [7:0]       n_byte;
    logic [LEN_W-1:0] pos;
    logic [SIG_IDX_W-1:0] sel;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.clear) begin
            n_byte = 8'd0;
        end else if (i_ctl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'd0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign pos = i_len - CELL_K - LEN_W'(1);
    assign sel = pos[SIG_IDX_W-1:0];

    always_comb begin
        if (CELL_K >= i_len) begin
            o_match = 1'b1;
        end else if (pos >= SIG_N) begin
            o_match = 1'b1;
        end else if (!i_care[sel]) begin
            o_match = 1'b1;
        end else begin
            o_match = (i_sig[sel] == i_byte);
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

// ----- hw/rtl/wildcard_byte_pattern_scanner.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Scans a byte stream for the first match of a masked signature.
// ----------------------------------------------------------------------------
// Input requests (i_valid/o_ready) carry one image byte each, with
// i_last_byte on the final byte. Result requests (o_valid/i_ready) carry
// o_found and o_match_offset: one result on the first match of an image, or
// a not-found result on the final byte when nothing matched.
// The signature lives in an APB register file at byte addresses 0, 8, 16, 24
// (pattern low, pattern high, care mask, length); pready is always high.
// A chain of MAX_PATTERN cells holds the byte history; every accepted byte
// other than a final one shifts the chain while no match is held, and all
// cells compare in parallel in the same cycle; the result is registered.
// Throughput is one byte per cycle, set by the single output register:
// o_ready stays high while the result register is empty or being taken.
// When the receiver stalls with a result pending, o_ready drops until the
// result is taken. Reset clears the registers, the window, the byte count
// and the match flag; the length register resets to 1. Window, count and
// flag also clear after every final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scanner #(
    parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [wbps_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire  [wbps_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [wbps_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire  [7:0]                           i_data_byte,
    input  wire                                  i_last_byte,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic                                 o_found,
    output logic [wbps_pkg::RESULT_OFF_W-1:0]    o_match_offset
);
    import wbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 32);
    localparam int SUB_W = (OFFSET_BITS > RESULT_OFF_W) ? OFFSET_BITS : RESULT_OFF_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    logic [63:0]          r_pat_low;
    logic [63:0]          r_pat_high;
    logic [CARE_W-1:0]    r_care;
    logic [PLEN_W-1:0]    r_plen;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    logic [OFFSET_BITS-1:0]  r_seen;
    logic [OFFSET_BITS-1:0]  n_seen;
    logic [OFFSET_BITS-1:0]  seen_now;
    logic [OFFSET_BITS-1:0]  diff;
    logic [SUB_W-1:0]        diff_ext;
    logic                    r_matched;
    logic                    n_matched;
    logic                    r_out_valid;
    logic                    r_found;
    logic [RESULT_OFF_W-1:0] r_offset;

    logic [LEN_W-1:0]      plen_ext;
    logic [LEN_W-1:0]      eff_len;
    logic                  fire;
    logic                  active;
    logic                  enough;
    logic                  hit;
    logic                  emit;
    t_sig                  sig;
    t_cell_ctl             ctl;
    logic [MAX_PATTERN:0][7:0] chain;
    logic [MAX_PATTERN-1:0]    cell_match;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= 64'd0;
            r_pat_high <= 64'd0;
            r_care     <= '0;
            r_plen     <= PLEN_W'(1);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_PAT_LOW:  r_pat_low  <= pwdata;
                REG_PAT_HIGH: r_pat_high <= pwdata;
                REG_CARE:     r_care     <= pwdata[CARE_W-1:0];
                REG_PLEN:     r_plen     <= pwdata[PLEN_W-1:0];
                default:      r_plen     <= r_plen;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PAT_LOW:  prdata = r_pat_low;
            REG_PAT_HIGH: prdata = r_pat_high;
            REG_CARE:     prdata = APB_DATA_W'(r_care);
            REG_PLEN:     prdata = APB_DATA_W'(r_plen);
            default:      prdata = '0;
        endcase
    end

    // effective length: zero acts as one, clamp to the window depth
    assign plen_ext = LEN_W'(r_plen);
    always_comb begin
        if (plen_ext == '0) begin
            eff_len = LEN_W'(1);
        end else if (plen_ext > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = plen_ext;
        end
    end

    assign sig = {r_pat_high, r_pat_low};

    // handshake
    assign o_ready   = !r_out_valid || i_ready;
    assign fire      = i_valid && o_ready;
    assign active    = !r_matched;
    assign ctl.shift = fire && active && !i_last_byte;
    assign ctl.clear = fire && i_last_byte;

    // window chain
    assign chain[0] = i_data_byte;
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        wbps_cell #(
            .IDX   (k),
            .LEN_W (LEN_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_byte  (chain[k]),
            .i_len   (eff_len),
            .i_sig   (sig),
            .i_care  (r_care),
            .o_byte  (chain[k+1]),
            .o_match (cell_match[k])
        );
    end

    // byte count, saturating
    assign seen_now = (r_seen == '1) ? r_seen : r_seen + OFFSET_BITS'(1);
    assign enough   = (seen_now >= OFFSET_BITS'(eff_len));
    assign hit      = enough && (&cell_match);
    assign diff     = seen_now - OFFSET_BITS'(eff_len);
    assign diff_ext = SUB_W'(diff);
    assign emit     = fire && active && (hit || i_last_byte);

    always_comb begin
        n_seen    = r_seen;
        n_matched = r_matched;
        if (fire) begin
            if (i_last_byte) begin
                n_seen    = '0;
                n_matched = 1'b0;
            end else if (active) begin
                n_seen    = seen_now;
                n_matched = hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_matched   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen    <= n_seen;
            r_matched <= n_matched;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_found  <= hit;
            r_offset <= hit ? diff_ext[RESULT_OFF_W-1:0] : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_found        = r_found;
    assign o_match_offset = r_offset;

endmodule

`default_nettype wire
